// ===== rtl/olid_pkg.sv =====
// Package for the ordered list core: request mode codes, field widths and
// the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package olid_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_FRONT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    typedef struct packed {
        logic capture;
        logic apply;
        logic idx_clr;
        logic idx_pos;
        logic idx_inc;
        logic shift_rd;
        logic shift_wr;
        logic del_done;
        logic dump_rd;
        logic out_load;
    } olid_cmd_t;

    typedef struct packed {
        logic del_hit;
        logic shift_more;
        logic out_taken;
        logic last_out;
    } olid_status_t;

endpackage

`default_nettype wire

// ===== rtl/olid_dp.sv =====
// Datapath of the ordered list core: circular element store, head and count
// registers, walk index, request registers and the result register.
// Depends on olid_pkg.
`default_nettype none

module olid_dp
    import olid_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [MODE_W-1:0]         mode,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic [POS_W-1:0]          position,
    input  wire olid_cmd_t                 cmd,
    output olid_status_t                   status,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [VALUE_W-1:0]      element,
    output logic                           last,
    output logic                           empty_res,
    output logic                           dropped
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    logic [MODE_W-1:0]  mode_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   position_reg;

    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          dropped_reg;
    logic          dropped_next;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] element_reg;
    logic               last_reg;
    logic               empty_reg;
    logic               out_dropped_reg;

    logic          is_insert;
    logic          full;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] idx_p1;
    logic [CW-1:0] idx_p1_c;
    logic          we;
    logic [IW-1:0] waddr;
    logic [VALUE_W-1:0] wdata;
    logic          re;
    logic [IW-1:0] raddr;

    function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [IW-1:0] k);
        logic [IW:0] s;
        s = {1'b0, h} + {1'b0, k};
        if (s >= (IW+1)'(CAPACITY))
        begin
            s = s - (IW+1)'(CAPACITY);
        end
        return s[IW-1:0];
    endfunction

    assign is_insert = (mode_reg == MODE_FRONT) || (mode_reg == MODE_BACK);
    assign full      = (count_reg == CW'(CAPACITY));
    assign head_dec  = (head_reg == '0) ? IW'(CAPACITY - 1) : head_reg - 1'b1;
    assign idx_p1    = idx_reg + 1'b1;
    assign idx_p1_c  = CW'(idx_reg) + 1'b1;

    assign status.del_hit    = (mode_reg == MODE_DELETE)
                               && (CMPW'(position_reg) < CMPW'(count_reg));
    assign status.shift_more = (idx_p1_c < count_reg);
    assign status.out_taken  = out_valid_reg && out_ready;
    assign status.last_out   = last_reg;

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        idx_next     = idx_reg;
        we           = 1'b0;
        waddr        = phys(head_reg, idx_reg);
        wdata        = rdata_reg;
        re           = 1'b0;
        raddr        = phys(head_reg, idx_reg);

        if (cmd.capture)
        begin
            dropped_next = 1'b0;
        end
        if (cmd.apply && is_insert)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                we         = 1'b1;
                wdata      = value_reg;
                count_next = count_reg + 1'b1;
                if (mode_reg == MODE_FRONT)
                begin
                    head_next = head_dec;
                    waddr     = head_dec;
                end
                else
                begin
                    waddr = phys(head_reg, IW'(count_reg));
                end
            end
        end
        if (cmd.shift_rd)
        begin
            re    = 1'b1;
            raddr = phys(head_reg, idx_p1);
        end
        if (cmd.shift_wr)
        begin
            we    = 1'b1;
            waddr = phys(head_reg, idx_reg);
            wdata = rdata_reg;
        end
        if (cmd.dump_rd)
        begin
            re    = 1'b1;
            raddr = phys(head_reg, idx_reg);
        end
        if (cmd.del_done)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_pos)
        begin
            idx_next = IW'(position_reg);
        end
        else if (cmd.idx_inc || cmd.shift_wr)
        begin
            idx_next = idx_p1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg     <= mode;
            value_reg    <= value;
            position_reg <= position;
        end
        if (cmd.out_load)
        begin
            element_reg     <= (count_reg == '0) ? '0 : rdata_reg;
            last_reg        <= (count_reg == '0) || (idx_p1_c == count_reg);
            empty_reg       <= (count_reg == '0);
            out_dropped_reg <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            dropped_reg <= dropped_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign element   = element_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;
    assign dropped   = out_dropped_reg;

endmodule

`default_nettype wire

// ===== rtl/olid_ctrl.sv =====
// Controller of the ordered list core: sequences request capture, insert,
// delete shifting and the per-element dump. Depends on olid_pkg.
`default_nettype none

module olid_ctrl
    import olid_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire olid_status_t status,
    output olid_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_SHIFT_RD = 3'd2;
    localparam logic [2:0] ST_SHIFT_WR = 3'd3;
    localparam logic [2:0] ST_DUMP_RD  = 3'd4;
    localparam logic [2:0] ST_DUMP_LD  = 3'd5;
    localparam logic [2:0] ST_DUMP_WT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.apply = 1'b1;
                if (status.del_hit)
                begin
                    cmd.idx_pos = 1'b1;
                    state_next  = ST_SHIFT_RD;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_DUMP_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                if (status.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
                else
                begin
                    cmd.del_done = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = ST_DUMP_RD;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_DUMP_RD:
            begin
                cmd.dump_rd = 1'b1;
                state_next  = ST_DUMP_LD;
            end
            ST_DUMP_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_DUMP_WT;
            end
            ST_DUMP_WT:
            begin
                if (status.out_taken)
                begin
                    if (status.last_out)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ordered_list_insert_delete_dump_core.sv =====
// Ordered list core: a request is captured, then applied; a delete that hits
// then moves each element behind the deleted one with a store read and then
// a store write; then each result takes a store read, a result load and a
// handoff that waits for out_ready. An empty list still yields one result. No new
// request is taken until the last result is handed off; the store has one read port.
// Reset empties the list; the store contents are left as they are.
`default_nettype none

module ordered_list_insert_delete_dump_core
    import olid_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [MODE_W-1:0]         mode,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic [POS_W-1:0]          position,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [VALUE_W-1:0]      element,
    output logic                           last,
    output logic                           empty_res,
    output logic                           dropped
);

    olid_cmd_t    cmd;
    olid_status_t status;

    olid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    olid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .value     (value),
        .position  (position),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .element   (element),
        .last      (last),
        .empty_res (empty_res),
        .dropped   (dropped)
    );

endmodule

`default_nettype wire
